// ----- design/periodic_task_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// periodic task scheduler assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

// ----- design/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the periodic task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int CMD_W        = 2;
	localparam int TASK_ID_W    = 2;
	localparam int MASK_BITS    = 4;
	localparam int TASK_COUNT_W = 3;
	localparam int PERIOD_W     = 16;
	localparam int TICK_W       = 32;
	localparam int PERIOD_REGS  = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_POLL  = 2'd1,
		CMD_START = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ZERO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ONE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TWO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THREE = 3'd4;

endpackage

// ----- design/periodic_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler
// table of periodic task timers driven by tick, poll, start and stop commands
// ----------------------------------------------------------------------------
// One command is taken per clock cycle while in_stall is low; each gives one
// fire_mask result through the command register, then the result register. All
// task deadlines are compared against the tick counter and advanced in
// parallel between those registers, so the rate does not depend on NUM_TASKS.
// A tick command increments the 32-bit tick counter, saturating at its maximum;
// a poll examines the first task_count tasks (capped at NUM_TASKS), gives
// every reached task a new deadline of ticks plus period (saturating) and
// flags the enabled ones in fire_mask; other commands return a zero mask.
// Writing a period register also loads that task's deadline with the period.
// Tasks at index four and above have no period register and no mask bit.
// The result register lets a new command in while a result waits.
module periodic_task_scheduler #(
	parameter int NUM_TASKS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  pts_pkg::cmd_t                     command,
	input  logic [pts_pkg::TASK_ID_W-1:0]     task_id,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pts_pkg::MASK_BITS-1:0]     fire_mask
);
	import pts_pkg::*;

	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int CMP_W = (CNT_W > TASK_COUNT_W) ? CNT_W : TASK_COUNT_W;
	localparam int PAD_W = (NUM_TASKS > MASK_BITS) ? NUM_TASKS : MASK_BITS;

	logic [TASK_COUNT_W-1:0] task_count_q;
	logic [PERIOD_W-1:0]     period_q   [NUM_TASKS];
	logic [TICK_W-1:0]       deadline_q [NUM_TASKS];
	logic [TICK_W-1:0]       tick_q;
	logic [NUM_TASKS-1:0]    enabled_q;

	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic [TASK_ID_W-1:0]    id_s1;
	logic                    out_valid_q;
	logic [MASK_BITS-1:0]    fire_mask_q;

	logic                    advance;
	logic                    accept;
	logic                    do_item;
	logic [NUM_TASKS-1:0]    reached;
	logic [NUM_TASKS-1:0]    id_hit;
	logic [NUM_TASKS-1:0]    period_wr;
	logic [TICK_W-1:0]       next_deadline [NUM_TASKS];
	logic [TICK_W:0]         dl_sum        [NUM_TASKS];
	logic [PAD_W-1:0]        fire_all;
	logic [MASK_BITS-1:0]    poll_mask;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign do_item   = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign fire_mask = fire_mask_q;

	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			reached[i] = (CMP_W'(i) < CMP_W'(task_count_q)) && (tick_q >= deadline_q[i]);
			dl_sum[i] = {1'b0, tick_q} + {{(TICK_W + 1 - PERIOD_W){1'b0}}, period_q[i]};
			next_deadline[i] = dl_sum[i][TICK_W] ? '1 : dl_sum[i][TICK_W-1:0];
			id_hit[i] = (CMP_W'(id_s1) == CMP_W'(i));
			// only the first four tasks have a period register
			period_wr[i] = (i < PERIOD_REGS) && cfg_write
				&& (cfg_index == CFG_IDX_W'(int'(REG_PERIOD_ZERO) + i));
		end
		fire_all  = PAD_W'(reached & enabled_q);
		poll_mask = fire_all[MASK_BITS-1:0];
	end

	// transfer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || in_stall;
			out_valid_q <= do_item || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			id_s1  <= task_id;
		end
		if (do_item) begin
			fire_mask_q <= (cmd_s1 == CMD_POLL) ? poll_mask : '0;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			tick_q       <= '0;
			enabled_q    <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				period_q[i]   <= '0;
				deadline_q[i] <= '0;
			end
		end else begin
			if (do_item) begin
				case (cmd_s1)
					CMD_TICK: begin
						if (tick_q != '1) begin
							tick_q <= tick_q + TICK_W'(1);
						end
					end
					CMD_POLL: begin
						for (int i = 0; i < NUM_TASKS; i++) begin
							if (reached[i]) begin
								deadline_q[i] <= next_deadline[i];
							end
						end
					end
					CMD_START: enabled_q <= enabled_q | id_hit;
					CMD_STOP:  enabled_q <= enabled_q & ~id_hit;
					default: ;
				endcase
			end
			if (cfg_write && cfg_index == REG_TASK_COUNT) begin
				task_count_q <= cfg_data[TASK_COUNT_W-1:0];
			end
			for (int i = 0; i < NUM_TASKS; i++) begin
				if (period_wr[i]) begin
					period_q[i]   <= cfg_data[PERIOD_W-1:0];
					deadline_q[i] <= TICK_W'(cfg_data[PERIOD_W-1:0]);
				end
			end
		end
	end

endmodule

// ----- design/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// port-level checks of the periodic task scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_macros.svh"

module pts_checker #(
	parameter int NUM_TASKS = 4
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pts_pkg::MASK_BITS-1:0] fire_mask
);
	import pts_pkg::*;

	localparam int WIDE_W = MASK_BITS + 5;

	// a waiting result holds until its transfer
	`PTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(fire_mask))

	// input side only backs up when the result side is full and stalled
	`PTS_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// no mask bit for a task that does not exist
	`PTS_ASSERT_IMPL(a_mask_range, clk, arst_n, out_valid, (WIDE_W'(fire_mask) >> NUM_TASKS) == '0)

endmodule

bind periodic_task_scheduler pts_checker #(
	.NUM_TASKS(NUM_TASKS)
) u_pts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.fire_mask (fire_mask)
);

// ----- bench/periodic_task_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_scheduler_tb
// checks every fire_mask transfer against a task table kept in the bench;
// directed commands and then random commands under several register
// settings, with random receiver stall bursts and sender idle gaps on the two channels
// ----------------------------------------------------------------------------
module periodic_task_scheduler_tb;
	import pts_pkg::*;

	localparam int NUM_TASKS = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 235;

	// tracks the task table and holds the masks that should come out next
	class task_table_model;
		bit [TASK_COUNT_W-1:0] task_count;
		bit [PERIOD_W-1:0]     period[NUM_TASKS];
		bit [TICK_W-1:0]       ticks;
		bit [TICK_W-1:0]       deadline[NUM_TASKS];
		bit                    enabled[NUM_TASKS];
		bit [MASK_BITS-1:0]    expected_masks[$];
		int mismatches;
		int commands;
		int polls;
		int masks_checked;
		int masks_fired;

		function new();
			task_count = '0;
			ticks = '0;
			foreach (period[i]) begin
				period[i] = '0;
				deadline[i] = '0;
				enabled[i] = 1'b0;
			end
		endfunction

		function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
			int k;
			case (idx)
				REG_TASK_COUNT: begin
					task_count = data[TASK_COUNT_W-1:0];
				end
				REG_PERIOD_ZERO, REG_PERIOD_ONE, REG_PERIOD_TWO, REG_PERIOD_THREE: begin
					k = int'(idx) - int'(REG_PERIOD_ZERO);
					if (k < NUM_TASKS) begin
						period[k] = data[PERIOD_W-1:0];
						deadline[k] = {{(TICK_W-PERIOD_W){1'b0}}, period[k]};
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void note_command(cmd_t cmd, bit [TASK_ID_W-1:0] id);
			bit [MASK_BITS-1:0] mask;
			bit [TICK_W:0] sum;
			int n;
			mask = '0;
			commands++;
			case (cmd)
				CMD_TICK: begin
					if (ticks != '1)
						ticks = ticks + 1;
				end
				CMD_POLL: begin
					polls++;
					n = (task_count > NUM_TASKS) ? NUM_TASKS : task_count;
					for (int i = 0; i < n; i++) begin
						if (ticks >= deadline[i]) begin
							sum = {1'b0, ticks} + {{(TICK_W+1-PERIOD_W){1'b0}}, period[i]};
							// deadline saturates instead of wrapping
							deadline[i] = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
							if (enabled[i] && i < MASK_BITS)
								mask[i] = 1'b1;
						end
					end
				end
				CMD_START: begin
					if (id < NUM_TASKS)
						enabled[id] = 1'b1;
				end
				default: begin
					if (id < NUM_TASKS)
						enabled[id] = 1'b0;
				end
			endcase
			expected_masks.push_back(mask);
		endfunction

		function void check_mask(logic [MASK_BITS-1:0] mask);
			bit [MASK_BITS-1:0] want;
			if (expected_masks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: fire_mask %h with no command pending", $realtime, mask);
			end else begin
				want = expected_masks.pop_front();
				masks_checked++;
				if (want != 0)
					masks_fired++;
				if (mask !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: fire_mask expected %h got %h", $realtime, want, mask);
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	cmd_t                    command;
	logic [TASK_ID_W-1:0]    task_id;
	logic                    out_valid;
	logic                    out_stall;
	logic [MASK_BITS-1:0]    fire_mask;

	task_table_model table_h;
	bit tx_idle_on;
	bit rx_idle_on;
	int settings_used;

	periodic_task_scheduler #(
		.NUM_TASKS(NUM_TASKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.task_id(task_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fire_mask(fire_mask)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[periodic_task_scheduler] ERROR");
		$finish;
	end

	// receiver stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			table_h.check_mask(fire_mask);
	end

	task automatic send_command(cmd_t cmd, logic [TASK_ID_W-1:0] id);
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		task_id <= id;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		table_h.note_command(cmd, id);
	endtask

	task automatic sender_gap();
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	// hold off the sender until every pending mask has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (table_h.expected_masks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		table_h.write_reg(idx, data);
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_period();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return CFG_DATA_W'($urandom_range(0, 65535));
		return CFG_DATA_W'($urandom_range(1, 24));
	endfunction

	task automatic random_settings(int phase);
		logic [TASK_COUNT_W-1:0] count;
		count = TASK_COUNT_W'($urandom_range(0, 7));
		if (phase == 1)
			count = '0;
		else if (phase == 2)
			count = '1;
		else if (phase == 3 || phase == PHASES - 1)
			count = TASK_COUNT_W'(NUM_TASKS);
		write_reg(REG_TASK_COUNT, CFG_DATA_W'(count));
		write_reg(REG_PERIOD_ZERO, random_period());
		write_reg(REG_PERIOD_ONE, random_period());
		write_reg(REG_PERIOD_TWO, random_period());
		write_reg(REG_PERIOD_THREE, random_period());
		// indexes past the last period register are ignored
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_PERIOD_THREE) + 1, 7)),
			CFG_DATA_W'($urandom_range(0, 65535)));
		settings_used++;
	endtask

	function automatic cmd_t random_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return CMD_TICK;
		if (r < 75)
			return CMD_POLL;
		if (r < 87)
			return CMD_START;
		if (r < 93)
			return CMD_STOP;
		return cmd_t'($urandom_range(0, 3));
	endfunction

	initial begin
		table_h = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_TICK;
		task_id = '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		settings_used = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset state: no tasks registered
		send_command(CMD_POLL, 2'd3);
		send_command(CMD_TICK, 2'd2);
		drain();

		// oversized task count, zero and maximum periods, unknown indexes
		write_reg(REG_TASK_COUNT, 16'd7);
		write_reg(REG_PERIOD_ZERO, 16'd0);
		write_reg(REG_PERIOD_ONE, 16'd1);
		write_reg(REG_PERIOD_TWO, 16'hFFFF);
		write_reg(REG_PERIOD_THREE, 16'd3);
		write_reg(REG_PERIOD_THREE + 3'd1, 16'hFFFF);
		write_reg(REG_PERIOD_THREE + 3'd2, 16'h5A5A);
		write_reg(REG_PERIOD_THREE + 3'd3, 16'hA5A5);
		settings_used++;
		send_command(CMD_POLL, 2'd0);
		send_command(CMD_START, 2'd0);
		send_command(CMD_START, 2'd1);
		send_command(CMD_START, 2'd2);
		send_command(CMD_START, 2'd3);
		send_command(CMD_POLL, 2'd1);
		send_command(CMD_TICK, 2'd3);
		send_command(CMD_POLL, 2'd2);
		send_command(CMD_STOP, 2'd2);
		send_command(CMD_TICK, 2'd0);
		send_command(CMD_TICK, 2'd1);
		send_command(CMD_TICK, 2'd2);
		send_command(CMD_POLL, 2'd3);
		send_command(CMD_STOP, 2'd0);
		send_command(CMD_STOP, 2'd3);
		send_command(CMD_POLL, 2'd0);
		send_command(CMD_TICK, 2'd0);
		send_command(CMD_POLL, 2'd0);
		send_command(CMD_STOP, 2'd1);
		send_command(CMD_POLL, 2'd0);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			random_settings(phase);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 60 == 0) begin
					tx_idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
					rx_idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
				end
				if (phase == 3 && n == 100)
					drain();
				send_command(random_command(), TASK_ID_W'($urandom_range(0, 3)));
				sender_gap();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("%0d commands checked under %0d register settings", table_h.masks_checked,
			settings_used);
		$display("%0d polls, %0d of them with tasks firing", table_h.polls,
			table_h.masks_fired);
		if (table_h.mismatches == 0 && table_h.expected_masks.size() == 0) begin
			$display("[periodic_task_scheduler] OK");
		end else begin
			$display("%0d mismatches, %0d masks missing", table_h.mismatches,
				table_h.expected_masks.size());
			$display("[periodic_task_scheduler] ERROR");
		end
		$finish;
	end

endmodule

// ----- periodic_task_scheduler.f -----
+incdir+design
design/pts_pkg.sv
design/periodic_task_scheduler.sv
design/pts_checker.sv
bench/periodic_task_scheduler_tb.sv
